@@ src/markup_to_printer_command_translator_assert.svh @@
// Assertion macros for the markup to printer command translator.
// Included by modules that check their own control logic; no other dependencies.
`ifndef MARKUP_TO_PRINTER_COMMAND_TRANSLATOR_ASSERT_SVH
`define MARKUP_TO_PRINTER_COMMAND_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MPCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mpct_pkg.sv @@
// Shared types and constants for the markup to printer command translator.
// No dependencies.
package mpct_pkg;

  localparam int unsigned MaxChunkRowsDef = 255;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [5:0] MaxRowBytesRst  = 6'd48;
  localparam logic [3:0] SymbologyRst    = 4'd8;
  localparam logic [2:0] ModuleWidthRst  = 3'd3;
  localparam logic [1:0] LabelPosRst     = 2'd2;

  localparam logic [1:0] CfgMaxRowBytes = 2'd0;
  localparam logic [1:0] CfgSymbology   = 2'd1;
  localparam logic [1:0] CfgModuleWidth = 2'd2;
  localparam logic [1:0] CfgLabelPos    = 2'd3;

  typedef enum logic [2:0] {
    K_BYTE,
    K_HTML,
    K_STYLE,
    K_UL,
    K_ALIGN,
    K_BARCODE,
    K_IMG_START,
    K_IMG_DATA
  } kind_e;

  // One queued command: a single byte, a fixed sequence with one value,
  // or up to three decoded image bytes.
  typedef struct packed {
    kind_e           kind;
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
  } ent_t;

  typedef struct packed {
    logic [5:0] max_row_bytes;
    logic [3:0] symbology;
    logic [2:0] module_width;
    logic [1:0] label_pos;
  } cfg_t;

endpackage

@@ src/mpct_if.sv @@
// Stream interfaces for the markup input and the printer byte output.
// No dependencies.
interface mpct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mpct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

@@ src/mpct_front.sv @@
// Front end: text/tag parser, tag tokenizer and base64 decoder.
// Classifies each input byte into at most one queued command. Uses mpct_pkg.
module mpct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    byte_i,
  input  logic          q_full_i,
  output logic          ready_o,
  output logic          push_o,
  output mpct_pkg::ent_t ent_o
);
  import mpct_pkg::*;

  localparam logic [2:0] PmToken   = 3'd0;
  localparam logic [2:0] PmText    = 3'd1;
  localparam logic [2:0] PmForce   = 3'd2;
  localparam logic [2:0] PmBarcode = 3'd3;
  localparam logic [2:0] PmImage   = 3'd4;

  localparam logic [7:0] TsStart   = 8'd0;
  localparam logic [7:0] TsH       = 8'd210;
  localparam logic [7:0] TsHtml    = 8'd15;
  localparam logic [7:0] TsHead    = 8'd20;
  localparam logic [7:0] TsB       = 8'd25;
  localparam logic [7:0] TsBody    = 8'd30;
  localparam logic [7:0] TsBig     = 8'd35;
  localparam logic [7:0] TsBr      = 8'd27;
  localparam logic [7:0] TsBarcode = 8'd228;
  localparam logic [7:0] TsI       = 8'd40;
  localparam logic [7:0] TsInvert  = 8'd45;
  localparam logic [7:0] TsImg     = 8'd50;
  localparam logic [7:0] TsU       = 8'd55;
  localparam logic [7:0] TsS       = 8'd60;
  localparam logic [7:0] TsSmall   = 8'd63;
  localparam logic [7:0] TsLeft    = 8'd65;
  localparam logic [7:0] TsRight   = 8'd70;
  localparam logic [7:0] TsCenter  = 8'd75;
  localparam logic [7:0] TsMeta    = 8'd80;
  localparam logic [7:0] TsBad     = 8'd200;
  localparam logic [7:0] TsAfter   = 8'd254;

  // Tag commands, keyed by tag code plus closing flag.
  localparam logic [7:0] CmdHtml      = 8'd15;
  localparam logic [7:0] CmdInvOn     = 8'd45;
  localparam logic [7:0] CmdInvOff    = 8'd46;
  localparam logic [7:0] CmdBoldOn    = 8'd25;
  localparam logic [7:0] CmdBoldOff   = 8'd26;
  localparam logic [7:0] CmdStrikeOn  = 8'd60;
  localparam logic [7:0] CmdStrikeOff = 8'd61;
  localparam logic [7:0] CmdBr        = 8'd27;
  localparam logic [7:0] CmdUlOn      = 8'd55;
  localparam logic [7:0] CmdUlOff     = 8'd56;
  localparam logic [7:0] CmdCenter    = 8'd75;
  localparam logic [7:0] CmdRight     = 8'd70;
  localparam logic [7:0] CmdCenterOff = 8'd76;
  localparam logic [7:0] CmdLeft      = 8'd65;
  localparam logic [7:0] CmdLeftOff   = 8'd66;
  localparam logic [7:0] CmdRightOff  = 8'd71;

  function automatic logic [6:0] sextet_of(input logic [7:0] v);
    logic [6:0] r;
    r = 7'd0;
    if (v inside {[8'h41:8'h5A]}) r = {1'b1, 6'(v - 8'h41)};
    else if (v inside {[8'h61:8'h7A]}) r = {1'b1, 6'(v - 8'h61 + 8'd26)};
    else if (v inside {[8'h30:8'h39]}) r = {1'b1, 6'(v - 8'h30 + 8'd52)};
    else if (v == 8'h2B) r = {1'b1, 6'd62};
    else if (v == 8'h2F) r = {1'b1, 6'd63};
    return r;
  endfunction

  logic [2:0]      mode_q, mode_d;
  logic [7:0]      tag_q, tag_d;
  logic            close_q, close_d;
  logic [6:0]      style_q, style_d;
  logic [1:0]      scnt_q, scnt_d;
  logic [1:0]      pad_q, pad_d;
  logic [2:0][5:0] grp_q;
  logic            grp_we;
  logic            accept;
  logic            has_ent;
  logic [7:0]      c;
  logic [7:0]      code;
  logic [6:0]      sx;
  logic [7:0]      b0, b1, b2;

  assign c       = byte_i;
  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && has_ent;
  assign code    = tag_q + {7'd0, close_q};
  assign sx      = sextet_of(c);
  assign b0      = {grp_q[0], grp_q[1][5:4]};
  assign b1      = {grp_q[1][3:0], grp_q[2][5:2]};
  assign b2      = {grp_q[2][1:0], sx[5:0]};

  always_comb begin
    mode_d  = mode_q;
    tag_d   = tag_q;
    close_d = close_q;
    style_d = style_q;
    scnt_d  = scnt_q;
    pad_d   = pad_q;
    grp_we  = 1'b0;
    has_ent = 1'b0;
    ent_o   = '0;
    ent_o.kind = K_BYTE;
    case (mode_q)
      PmText: begin
        if (c == 8'h5C) begin
          mode_d = PmForce;
        end else if (c == 8'h3C) begin
          mode_d  = PmToken;
          tag_d   = TsStart;
          close_d = 1'b0;
        end else if (c != 8'h0A) begin
          has_ent       = 1'b1;
          ent_o.data[0] = c;
        end
      end
      PmForce: begin
        has_ent       = 1'b1;
        ent_o.data[0] = c;
        mode_d        = PmText;
      end
      PmBarcode: begin
        has_ent = 1'b1;
        if (c == 8'h22) begin
          ent_o.data[0] = 8'h00;
          mode_d        = PmToken;
          tag_d         = TsAfter;
          close_d       = 1'b0;
        end else begin
          ent_o.data[0] = c;
        end
      end
      PmImage: begin
        ent_o.kind = K_IMG_DATA;
        if (c == 8'h22 || c == 8'h00) begin
          // flush a padded group
          ent_o.data[0] = b0;
          ent_o.data[1] = b1;
          if (pad_q == 2'd1) begin
            has_ent   = 1'b1;
            ent_o.cnt = 2'd2;
          end else if (pad_q != 2'd0) begin
            has_ent   = 1'b1;
            ent_o.cnt = 2'd1;
          end
          if (c == 8'h22) begin
            mode_d  = PmToken;
            tag_d   = TsAfter;
            close_d = 1'b0;
          end
        end else if (c == 8'h3D) begin
          if (pad_q != 2'd3) pad_d = pad_q + 2'd1;
        end else if (sx[6]) begin
          if (scnt_q == 2'd3) begin
            has_ent       = 1'b1;
            ent_o.cnt     = 2'd3;
            ent_o.data[0] = b0;
            ent_o.data[1] = b1;
            ent_o.data[2] = b2;
            scnt_d        = 2'd0;
          end else begin
            grp_we = 1'b1;
            scnt_d = scnt_q + 2'd1;
          end
        end
      end
      default: begin
        case (c)
          8'h3C: tag_d = TsStart;
          8'h3E: begin
            mode_d  = PmText;
            tag_d   = TsStart;
            close_d = 1'b0;
            case (code)
              CmdHtml: begin
                has_ent    = 1'b1;
                ent_o.kind = K_HTML;
                style_d    = 7'd0;
              end
              CmdInvOn, CmdInvOff, CmdBoldOn, CmdBoldOff, CmdStrikeOn, CmdStrikeOff: begin
                has_ent    = 1'b1;
                ent_o.kind = K_STYLE;
                case (code)
                  CmdInvOn:    style_d = style_q | 7'h02;
                  CmdInvOff:   style_d = style_q & ~7'h02;
                  CmdBoldOn:   style_d = style_q | 7'h08;
                  CmdBoldOff:  style_d = style_q & ~7'h08;
                  CmdStrikeOn: style_d = style_q | 7'h40;
                  default:     style_d = style_q & ~7'h40;
                endcase
                ent_o.data[0] = {1'b0, style_d};
              end
              CmdBr: begin
                has_ent       = 1'b1;
                ent_o.data[0] = 8'h0A;
              end
              CmdUlOn, CmdUlOff: begin
                has_ent       = 1'b1;
                ent_o.kind    = K_UL;
                ent_o.data[0] = (code == CmdUlOn) ? 8'd1 : 8'd0;
              end
              CmdCenter, CmdRight, CmdCenterOff, CmdLeft, CmdLeftOff, CmdRightOff: begin
                has_ent    = 1'b1;
                ent_o.kind = K_ALIGN;
                if (code == CmdCenter) ent_o.data[0] = 8'd1;
                else if (code == CmdRight) ent_o.data[0] = 8'd2;
                else ent_o.data[0] = 8'd0;
              end
              default: ;
            endcase
          end
          8'h2F: if (tag_q == TsStart) close_d = 1'b1;
          8'h68: if (tag_q == TsStart) tag_d = TsH;
          8'h74: if (tag_q == TsH) tag_d = TsHtml;
          8'h65: if (tag_q == TsH) tag_d = TsHead;
          8'h62: if (tag_q == TsStart) tag_d = TsB;
          8'h61: if (tag_q == TsB) tag_d = TsBarcode;
          8'h22: begin
            if (tag_q == TsBarcode) begin
              has_ent    = 1'b1;
              ent_o.kind = K_BARCODE;
              mode_d     = PmBarcode;
            end else if (tag_q == TsImg) begin
              has_ent    = 1'b1;
              ent_o.kind = K_IMG_START;
              mode_d     = PmImage;
              scnt_d     = 2'd0;
              pad_d      = 2'd0;
            end
          end
          8'h69: begin
            if (tag_q == TsB) tag_d = TsBig;
            else if (tag_q == TsStart) tag_d = TsI;
          end
          8'h6F: if (tag_q == TsB) tag_d = TsBody;
          8'h6D: begin
            if (tag_q == TsStart) tag_d = TsMeta;
            else if (tag_q == TsI) tag_d = TsImg;
            else if (tag_q == TsS) tag_d = TsSmall;
          end
          8'h6E: if (tag_q == TsI) tag_d = TsInvert;
          8'h73: if (tag_q == TsStart) tag_d = TsS;
          8'h6C: if (tag_q == TsStart) tag_d = TsLeft;
          8'h72: begin
            if (tag_q == TsStart) tag_d = TsRight;
            else if (tag_q == TsB) tag_d = TsBr;
          end
          8'h63: if (tag_q == TsStart) tag_d = TsCenter;
          8'h75: if (tag_q == TsStart) tag_d = TsU;
          default: if (tag_q == TsStart) tag_d = TsBad;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= PmToken;
      tag_q   <= TsStart;
      close_q <= 1'b0;
      style_q <= 7'd0;
      scnt_q  <= 2'd0;
      pad_q   <= 2'd0;
    end else if (accept) begin
      mode_q  <= mode_d;
      tag_q   <= tag_d;
      close_q <= close_d;
      style_q <= style_d;
      scnt_q  <= scnt_d;
      pad_q   <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && grp_we) grp_q[scnt_q] <= sx[5:0];
  end

endmodule

@@ src/mpct_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Uses mpct_pkg and the assertion macro header.
module mpct_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpct_pkg::ent_t ent_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output mpct_pkg::ent_t head_o
);
  import mpct_pkg::*;
  `include "markup_to_printer_command_translator_assert.svh"

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ent_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

  `MPCT_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `MPCT_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `MPCT_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(QueueDepth), "count overflow")
  `MPCT_ASSERT_NEXT(a_cnt_inc, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count did not advance")

endmodule

@@ src/mpct_back.sv @@
// Back end: expands queued commands into printer bytes, runs the image
// header and raster chunk counters, and holds the output register. Uses mpct_pkg.
module mpct_back #(
  parameter int unsigned MAX_CHUNK_ROWS = mpct_pkg::MaxChunkRowsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mpct_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  mpct_pkg::ent_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  input  logic           out_ready_i
);
  import mpct_pkg::*;

  localparam logic [7:0] MaxRows = 8'(MAX_CHUNK_ROWS);

  function automatic logic [4:0] seq_len(input kind_e k);
    logic [4:0] r;
    case (k)
      K_HTML:    r = 5'd21;
      K_STYLE:   r = 5'd3;
      K_UL:      r = 5'd3;
      K_ALIGN:   r = 5'd3;
      K_BARCODE: r = 5'd9;
      default:   r = 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seq_byte(input kind_e k, input logic [4:0] p,
                                          input logic [7:0] v, input cfg_t cf);
    logic [7:0] r;
    r = v;
    case (k)
      K_HTML: begin
        case (p)
          5'd0:    r = 8'hFF;
          5'd12:   r = 8'h40;
          5'd14:   r = 8'h37;
          5'd15:   r = 8'h14;
          5'd16:   r = 8'hFF;
          5'd17:   r = 8'hFA;
          5'd18:   r = 8'h12;
          5'd19:   r = 8'h23;
          5'd20:   r = 8'h01;
          default: r = 8'h1B;
        endcase
      end
      K_STYLE: r = (p == 5'd0) ? 8'h1B : (p == 5'd1) ? 8'h21 : v;
      K_UL:    r = (p == 5'd0) ? 8'h1B : (p == 5'd1) ? 8'h2D : v;
      K_ALIGN: r = (p == 5'd0) ? 8'h1B : (p == 5'd1) ? 8'h61 : v;
      K_BARCODE: begin
        case (p)
          5'd0, 5'd3, 5'd6: r = 8'h1D;
          5'd1:    r = 8'h48;
          5'd2:    r = {6'd0, cf.label_pos};
          5'd4:    r = 8'h77;
          5'd5:    r = {5'd0, cf.module_width};
          5'd7:    r = 8'h6B;
          default: r = {4'd0, cf.symbology};
        endcase
      end
      default: r = v;
    endcase
    return r;
  endfunction

  logic [4:0]  pos_q, pos_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [2:0]  sub_q, sub_d;
  logic [7:0]  rows_q, rows_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [15:0] width_q, width_d, height_q, height_d, started_q, started_d;
  logic [5:0]  rb_q, rb_d;
  logic [13:0] chunk_q, chunk_d;
  logic        ov_q, ov_d, ol_q, ol_d;
  logic [7:0]  ob_q, ob_d;

  logic        step, lastb, exhausted;
  logic [7:0]  c;
  logic [15:0] rem;
  logic [16:0] wsum;
  logic [13:0] chunk_dec;

  assign step      = !empty_i && (!ov_q || out_ready_i);
  assign c         = head_i.data[bidx_q];
  assign lastb     = (bidx_q == head_i.cnt - 2'd1);
  assign exhausted = (started_q >= height_q);
  assign rem       = height_q - started_q;
  assign wsum      = {1'b0, width_q} + 17'd7;
  assign chunk_dec = (chunk_q != '0) ? chunk_q - 14'd1 : chunk_q;

  always_comb begin
    pos_d     = pos_q;
    bidx_d    = bidx_q;
    sub_d     = sub_q;
    rows_d    = rows_q;
    hpos_d    = hpos_q;
    width_d   = width_q;
    height_d  = height_q;
    started_d = started_q;
    rb_d      = rb_q;
    chunk_d   = chunk_q;
    ov_d      = ov_q && !out_ready_i;
    ob_d      = ob_q;
    ol_d      = ol_q;
    pop_o     = 1'b0;
    if (step) begin
      case (head_i.kind)
        K_IMG_START: begin
          hpos_d    = 3'd0;
          width_d   = '0;
          height_d  = '0;
          rb_d      = '0;
          started_d = '0;
          chunk_d   = '0;
          pop_o     = 1'b1;
        end
        K_IMG_DATA: begin
          case (sub_q)
            3'd0: begin
              if (hpos_q < 3'd4) begin
                case (hpos_q[1:0])
                  2'd0: width_d = {8'd0, c};
                  2'd1: width_d = {c, width_q[7:0]};
                  2'd2: height_d = {8'd0, c};
                  default: begin
                    height_d  = {c, height_q[7:0]};
                    rb_d      = (wsum[16:3] >= {8'd0, cfg_i.max_row_bytes}) ?
                                cfg_i.max_row_bytes : wsum[8:3];
                    started_d = '0;
                    chunk_d   = '0;
                  end
                endcase
                hpos_d = hpos_q + 3'd1;
                pop_o  = lastb;
                bidx_d = lastb ? 2'd0 : bidx_q + 2'd1;
              end else if (chunk_q == '0) begin
                if (exhausted) begin
                  // drop the rest of this group
                  pop_o  = 1'b1;
                  bidx_d = 2'd0;
                end else begin
                  rows_d    = (rem > {8'd0, MaxRows}) ? MaxRows : rem[7:0];
                  started_d = started_q + ((rem > {8'd0, MaxRows}) ? {8'd0, MaxRows} : rem);
                  ov_d      = 1'b1;
                  ob_d      = 8'h12;
                  ol_d      = 1'b0;
                  sub_d     = 3'd1;
                end
              end else begin
                chunk_d = chunk_dec;
                ov_d    = 1'b1;
                ob_d    = c;
                ol_d    = lastb || ((chunk_dec == '0) && exhausted);
                pop_o   = lastb;
                bidx_d  = lastb ? 2'd0 : bidx_q + 2'd1;
              end
            end
            3'd1: begin
              chunk_d = 14'(rows_q * rb_q);
              ov_d    = 1'b1;
              ob_d    = 8'h2A;
              ol_d    = 1'b0;
              sub_d   = 3'd2;
            end
            3'd2: begin
              ov_d  = 1'b1;
              ob_d  = rows_q;
              ol_d  = 1'b0;
              sub_d = 3'd3;
            end
            3'd3: begin
              ov_d  = 1'b1;
              ob_d  = {2'd0, rb_q};
              ol_d  = 1'b0;
              sub_d = 3'd4;
            end
            default: begin
              chunk_d = chunk_dec;
              ov_d    = 1'b1;
              ob_d    = c;
              ol_d    = lastb || ((chunk_dec == '0) && exhausted);
              sub_d   = 3'd0;
              pop_o   = lastb;
              bidx_d  = lastb ? 2'd0 : bidx_q + 2'd1;
            end
          endcase
        end
        default: begin
          ov_d = 1'b1;
          ob_d = seq_byte(head_i.kind, pos_q, head_i.data[0], cfg_i);
          ol_d = (pos_q == seq_len(head_i.kind) - 5'd1);
          if (ol_d) begin
            pop_o = 1'b1;
            pos_d = 5'd0;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      bidx_q    <= '0;
      sub_q     <= '0;
      hpos_q    <= '0;
      width_q   <= '0;
      height_q  <= '0;
      started_q <= '0;
      rb_q      <= '0;
      chunk_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      bidx_q    <= bidx_d;
      sub_q     <= sub_d;
      hpos_q    <= hpos_d;
      width_q   <= width_d;
      height_q  <= height_d;
      started_q <= started_d;
      rb_q      <= rb_d;
      chunk_q   <= chunk_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q <= rows_d;
    ob_q   <= ob_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

endmodule

@@ src/markup_to_printer_command_translator.sv @@
// Top level of the markup to printer command translator: configuration
// registers, front end, command queue and back end. Uses mpct_pkg and mpct_if.
//
//   channel  dir  payload              beat
//   in_i     in   in_byte[7:0]         one markup byte
//   out_o    out  out_byte[7:0], last  one printer byte, last ends a run
//   cfg      in   cfg_idx_i, cfg_data_i  one register write on cfg_we_i
//
// The front end takes one byte per cycle while the two-entry queue has room.
// The back end sends one printer byte per cycle while a command is queued and
// out_o is not stalled; an image start, image header bytes and the rest of a
// group past the last row give no output; a raster chunk header adds 4 bytes.
// Reset, asynchronous and active low, sets control and config registers to
// defaults. Output stalls back up through the queue to in_i.ready.
module markup_to_printer_command_translator #(
  parameter int unsigned MAX_CHUNK_ROWS = mpct_pkg::MaxChunkRowsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpct_in_if.sink    in_i,
  mpct_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i
);
  import mpct_pkg::*;

  cfg_t cfg_q;
  ent_t push_ent, head;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_row_bytes <= MaxRowBytesRst;
      cfg_q.symbology     <= SymbologyRst;
      cfg_q.module_width  <= ModuleWidthRst;
      cfg_q.label_pos     <= LabelPosRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxRowBytes: cfg_q.max_row_bytes <= cfg_data_i;
        CfgSymbology:   cfg_q.symbology     <= cfg_data_i[3:0];
        CfgModuleWidth: cfg_q.module_width  <= cfg_data_i[2:0];
        CfgLabelPos:    cfg_q.label_pos     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  mpct_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .byte_i   (in_i.in_byte),
    .q_full_i (q_full),
    .ready_o  (in_i.ready),
    .push_o   (push),
    .ent_o    (push_ent)
  );

  mpct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (push_ent),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  mpct_back #(
    .MAX_CHUNK_ROWS (MAX_CHUNK_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last),
    .out_ready_i (out_o.ready)
  );

endmodule
